/* rtl/core/trp_pkg.sv */
// trp_pkg: shared constants, codes and types of the trace ring start/end pairer
// used by the interfaces, the pending table search unit and the top level
`timescale 1ns / 1ps

package trp_pkg;

	// ring geometry
	localparam int MAX_SLOTS  = 1024;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int SCNT_W     = SLOT_W + 1;
	localparam int RING_W     = 11;
	localparam int RING_RESET = 1024;

	// pending start table
	localparam int PEND_ENTRIES = 16;
	localparam int PEND_W       = (PEND_ENTRIES > 1) ? $clog2(PEND_ENTRIES) : 1;

	// field widths
	localparam int STAMP_W = 64;
	localparam int WORD_W  = 32;
	localparam int ACT_W   = 3;
	localparam int CNT_W   = 64;

	typedef logic [ACT_W-1:0]   act_t;
	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [PEND_W-1:0]  pend_idx_t;

	// result action codes
	localparam act_t ACT_EMPTY     = 3'd0;
	localparam act_t ACT_SEEN      = 3'd1;
	localparam act_t ACT_UNKNOWN   = 3'd2;
	localparam act_t ACT_PARKED    = 3'd3;
	localparam act_t ACT_PAIRED    = 3'd4;
	localparam act_t ACT_UNMATCHED = 3'd5;
	localparam act_t ACT_FULL      = 3'd6;

	// record type words
	localparam word_t KIND_START = 32'd1;
	localparam word_t KIND_END   = 32'd2;

	// sequencer to pending table
	typedef struct packed {
		logic      start;
		word_t     key;
		logic      wr;
		pend_idx_t wr_idx;
		logic      wr_valid;
		word_t     wr_key;
		stamp_t    wr_stamp;
	} pend_cmd_t;

	// pending table back to sequencer
	typedef struct packed {
		logic      done;
		logic      hit;
		pend_idx_t hit_idx;
		stamp_t    hit_stamp;
		logic      free;
		pend_idx_t free_idx;
	} pend_stat_t;

endpackage

/* rtl/core/trp_if.sv */
// trp_if: valid/ready channel interfaces for trace records and pairing results
// depends on trp_pkg
`timescale 1ns / 1ps

interface trp_rec_if
	import trp_pkg::*;
	();
	logic   valid;
	logic   ready;
	stamp_t stamp;
	word_t  record_kind;
	word_t  dispatch_index;

	modport source (output valid, stamp, record_kind, dispatch_index, input ready);
	modport sink   (input valid, stamp, record_kind, dispatch_index, output ready);
endinterface

interface trp_res_if
	import trp_pkg::*;
	();
	logic              valid;
	logic              ready;
	act_t              action;
	logic [SLOT_W-1:0] slot_read;
	logic              pair_valid;
	word_t             pair_index;
	stamp_t            start_stamp;
	stamp_t            end_stamp;
	logic [CNT_W-1:0]  pairs_total;

	modport source (output valid, action, slot_read, pair_valid, pair_index, start_stamp,
		end_stamp, pairs_total, input ready);
	modport sink   (input valid, action, slot_read, pair_valid, pair_index, start_stamp,
		end_stamp, pairs_total, output ready);
endinterface

/* rtl/core/trp_idx_ram.sv */
// trp_idx_ram: last consumed dispatch index per ring slot, one write and one read port
// depends on trp_pkg; read data is registered
`timescale 1ns / 1ps

module trp_idx_ram
	import trp_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [SLOT_W-1:0] waddr,
	input  word_t             wdata,
	input  logic              re,
	input  logic [SLOT_W-1:0] raddr,
	output word_t             rdata
);

	word_t mem [MAX_SLOTS];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/trp_pend_search.sv */
// trp_pend_search: pending start table with one shared key comparator
// walks one entry per cycle to find the first match and first free entry; depends on trp_pkg
`timescale 1ns / 1ps

module trp_pend_search
	import trp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  pend_cmd_t  cmd,
	output pend_stat_t stat
);

	logic [PEND_ENTRIES-1:0] valid_q;
	word_t                   key_q [PEND_ENTRIES];
	stamp_t                  stamp_q [PEND_ENTRIES];

	logic      busy_q;
	logic      done_q;
	pend_idx_t cnt_q;
	word_t     find_q;
	logic      hit_q;
	pend_idx_t hit_idx_q;
	stamp_t    hit_stamp_q;
	logic      free_q;
	pend_idx_t free_idx_q;

	logic   ent_valid;
	logic   ent_match;
	stamp_t ent_stamp;
	logic   last;

	// shared compare on the entry under the walk counter
	always_comb begin
		ent_valid = valid_q[cnt_q];
		ent_match = ent_valid && (key_q[cnt_q] == find_q);
		ent_stamp = stamp_q[cnt_q];
		last      = (cnt_q == PEND_W'(PEND_ENTRIES - 1));
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wr) begin
			valid_q[cmd.wr_idx] <= cmd.wr_valid;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			key_q[cmd.wr_idx]   <= cmd.wr_key;
			stamp_q[cmd.wr_idx] <= cmd.wr_stamp;
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (busy_q) begin
				if (ent_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!ent_valid && !free_q) begin
					free_q <= 1'b1;
				end
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// walk results
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			find_q <= cmd.key;
		end else if (busy_q) begin
			if (ent_match && !hit_q) begin
				hit_idx_q   <= cnt_q;
				hit_stamp_q <= ent_stamp;
			end
			if (!ent_valid && !free_q) begin
				free_idx_q <= cnt_q;
			end
		end
	end

	assign stat.done      = done_q;
	assign stat.hit       = hit_q;
	assign stat.hit_idx   = hit_idx_q;
	assign stat.hit_stamp = hit_stamp_q;
	assign stat.free      = free_q;
	assign stat.free_idx  = free_idx_q;

endmodule

/* rtl/core/trace_ring_start_end_pairer.sv */
// trace_ring_start_end_pairer: top level sequencer, cursor, pair counter, result register
// depends on trp_pkg, trp_if, trp_idx_ram and trp_pend_search
`timescale 1ns / 1ps

// Usage
// rec (sink) takes the trace record at the current read cursor: stamp, record_kind,
// dispatch_index. res (source) returns one result per record: action, slot_read,
// pair_valid, pair_index, start_stamp, end_stamp and pairs_total.
// cfg_we/cfg_wdata write ring_slots (0 acts as 1, above 1024 acts as 1024); a write
// sets the cursor to zero and starts a clearing pass over the slot index memory.
// An empty or already consumed record goes from the check state straight to the done
// state; any other record first runs the pending table walk, one entry per cycle over
// 16 entries through one key comparator, and then the update state. One record is in
// work at a time: a new record is taken only after the last has left the done state.
// Reset and every ring_slots write run a clearing pass over all 1024 slots, one slot a
// cycle, during which rec.ready stays low.
// The result sits in an output register; a new record is taken while it waits, and
// only the hand-off of the next result waits for res.ready.

module trace_ring_start_end_pairer
	import trp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [RING_W-1:0] cfg_wdata,
	trp_rec_if.sink           rec,
	trp_res_if.source         res
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]        state_q;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic [RING_W-1:0] ring_slots_q;
	logic [SLOT_W-1:0] cursor_q;
	logic [CNT_W-1:0]  pair_count_q;

	stamp_t            stamp_q;
	word_t             kind_q;
	word_t             idx_q;
	logic [SLOT_W-1:0] slot_q;

	act_t   res_action_q;
	logic   res_pvalid_q;
	stamp_t res_pstart_q;

	logic              out_valid_q;
	act_t              out_action_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_pvalid_q;
	word_t             out_pidx_q;
	stamp_t            out_pstart_q;
	stamp_t            out_pend_q;
	logic [CNT_W-1:0]  out_total_q;

	logic [31:0]       ring_ext;
	logic [SCNT_W-1:0] n_slots;
	logic [SLOT_W-1:0] slot_c;
	logic [SLOT_W-1:0] cursor_nxt;
	logic              rec_acc;
	logic              out_free;

	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	word_t             ram_wdata;
	word_t             ram_rdata;

	pend_cmd_t  pcmd;
	pend_stat_t pstat;

	act_t act_c;
	logic paired_c;

	// slots in use and read slot
	always_comb begin
		ring_ext = 32'(ring_slots_q);
		if (ring_ext == 32'd0) begin
			n_slots = SCNT_W'(1);
		end else if (ring_ext > 32'(MAX_SLOTS)) begin
			n_slots = SCNT_W'(MAX_SLOTS);
		end else begin
			n_slots = SCNT_W'(ring_ext);
		end
		slot_c = ({1'b0, cursor_q} >= n_slots) ? '0 : cursor_q;
		cursor_nxt = (({1'b0, slot_q} + 1'b1) >= n_slots) ? '0 : slot_q + 1'b1;
	end

	assign rec.ready = (state_q == ST_IDLE);
	assign rec_acc   = rec.valid && rec.ready;
	assign out_free  = !out_valid_q || res.ready;

	// slot index memory ports
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
		ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : slot_q;
		ram_wdata = (state_q == ST_CLEAR) ? '1 : idx_q;
	end

	trp_idx_ram u_idx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rec_acc),
		.raddr (slot_c),
		.rdata (ram_rdata)
	);

	// action decode and table update after the walk
	always_comb begin
		act_c         = ACT_UNKNOWN;
		paired_c      = 1'b0;
		pcmd          = '0;
		pcmd.key      = idx_q;
		pcmd.wr_key   = idx_q;
		pcmd.wr_stamp = stamp_q;
		pcmd.start    = (state_q == ST_CHECK) && (stamp_q != '0) && (ram_rdata != idx_q);
		if (state_q == ST_UPDATE) begin
			if (kind_q == KIND_START) begin
				if (pstat.hit) begin
					pcmd.wr       = 1'b1;
					pcmd.wr_idx   = pstat.hit_idx;
					pcmd.wr_valid = 1'b1;
					act_c         = ACT_PARKED;
				end else if (pstat.free) begin
					pcmd.wr       = 1'b1;
					pcmd.wr_idx   = pstat.free_idx;
					pcmd.wr_valid = 1'b1;
					act_c         = ACT_PARKED;
				end else begin
					act_c = ACT_FULL;
				end
			end else if (kind_q == KIND_END) begin
				if (pstat.hit) begin
					pcmd.wr       = 1'b1;
					pcmd.wr_idx   = pstat.hit_idx;
					pcmd.wr_valid = 1'b0;
					act_c         = ACT_PAIRED;
					paired_c      = 1'b1;
				end else begin
					act_c = ACT_UNMATCHED;
				end
			end
		end
	end

	trp_pend_search u_pend (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (pcmd),
		.stat   (pstat)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_cnt_q    <= '0;
			ring_slots_q <= RING_W'(RING_RESET);
			cursor_q     <= '0;
			pair_count_q <= '0;
		end else if (cfg_we) begin
			ring_slots_q <= cfg_wdata;
			cursor_q     <= '0;
			clr_cnt_q    <= '0;
			state_q      <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == SLOT_W'(MAX_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (rec_acc) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= pcmd.start ? ST_SEARCH : ST_DONE;
				end
				ST_SEARCH: begin
					if (pstat.done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					cursor_q <= cursor_nxt;
					if (paired_c) begin
						pair_count_q <= pair_count_q + 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// record capture and result assembly
	always_ff @(posedge clk) begin
		if (rec_acc) begin
			stamp_q <= rec.stamp;
			kind_q  <= rec.record_kind;
			idx_q   <= rec.dispatch_index;
			slot_q  <= slot_c;
		end
		if (state_q == ST_CHECK) begin
			res_action_q <= (stamp_q == '0) ? ACT_EMPTY : ACT_SEEN;
			res_pvalid_q <= 1'b0;
		end
		if (state_q == ST_UPDATE) begin
			res_action_q <= act_c;
			res_pvalid_q <= paired_c;
			res_pstart_q <= pstat.hit_stamp;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_action_q <= res_action_q;
			out_slot_q   <= slot_q;
			out_pvalid_q <= res_pvalid_q;
			out_pidx_q   <= res_pvalid_q ? idx_q : '0;
			out_pstart_q <= res_pvalid_q ? res_pstart_q : '0;
			out_pend_q   <= res_pvalid_q ? stamp_q : '0;
			out_total_q  <= pair_count_q;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.action      = out_action_q;
	assign res.slot_read   = out_slot_q;
	assign res.pair_valid  = out_pvalid_q;
	assign res.pair_index  = out_pidx_q;
	assign res.start_stamp = out_pstart_q;
	assign res.end_stamp   = out_pend_q;
	assign res.pairs_total = out_total_q;

endmodule
